>>> rtl/core/sts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the sorted table binary search block
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } sts_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic               load;
        logic               found;
        logic [INDEX_W-1:0] index;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/core/sts_table_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_table_mem
// single write port, single read port table memory with registered read data
// ----------------------------------------------------------------------------
module sts_table_mem
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_W      = 10
) (
    input  wire logic               aclk,
    input  wire mem_ctl_t           mem_ctl,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [VALUE_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_data <= table_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sts_search_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_search_ctrl
// accepts write and search beats, steps the binary search one probe at a time
// ----------------------------------------------------------------------------
module sts_search_ctrl
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_W      = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               operation,
    input  wire logic [INDEX_W-1:0] entry_index,
    input  wire logic [VALUE_W-1:0] entry_value,
    input  wire logic [COUNT_W-1:0] entry_count,
    input  wire logic               out_free,
    output mem_ctl_t                mem_ctl,
    output logic      [ADDR_W-1:0]  wr_addr,
    output logic      [ADDR_W-1:0]  rd_addr,
    input  wire logic [VALUE_W-1:0] rd_data,
    output result_t                 res
);

    localparam int AW1 = ADDR_W + 1;
    localparam int IW  = (AW1 > COUNT_W) ? AW1 : COUNT_W;
    localparam logic [IW-1:0] DEPTH_W = IW'(TABLE_DEPTH);

    sts_state_t state_reg, state_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    // half-open range [lo, hi)
    logic [AW1-1:0] lo_reg, lo_next;
    logic [AW1-1:0] hi_reg, hi_next;
    logic [AW1-1:0] mid_reg, mid_next;

    logic           accept;
    logic           idx_ok;
    logic [IW-1:0]  count_w;
    logic [IW-1:0]  count_eff;
    logic           range_ok;
    logic [AW1-1:0] mid;
    logic           eq;
    logic           less;

    assign accept    = s_tvalid && s_tready;
    assign idx_ok    = IW'(entry_index) < DEPTH_W;
    assign count_w   = IW'(entry_count);
    assign count_eff = (count_w > DEPTH_W) ? DEPTH_W : count_w;
    assign range_ok  = lo_reg < hi_reg;
    assign mid       = lo_reg + ((hi_reg - AW1'(1) - lo_reg) >> 1);
    assign eq        = rd_data == key_reg;
    assign less      = $signed(rd_data) < $signed(key_reg);

    assign wr_addr = ADDR_W'(entry_index);
    assign rd_addr = ADDR_W'(mid);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && operation == OP_SEARCH) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (range_ok) begin
                    state_next = ST_CMP;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (!eq) begin
                    state_next = ST_PROBE;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready      = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        res.load      = 1'b0;
        res.found     = 1'b0;
        res.index     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                mem_ctl.wr_en = s_tvalid && operation == OP_WRITE && idx_ok;
            end
            ST_PROBE: begin
                mem_ctl.rd_en = range_ok;
                res.load      = !range_ok && out_free;
            end
            ST_CMP: begin
                res.load  = eq && out_free;
                res.found = 1'b1;
                res.index = INDEX_W'(mid_reg);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // search datapath
    always_comb begin
        key_next = key_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next = entry_value;
                    lo_next  = '0;
                    hi_next  = AW1'(count_eff);
                end
            end
            ST_PROBE: begin
                mid_next = mid;
            end
            ST_CMP: begin
                if (!eq) begin
                    if (less) begin
                        lo_next = mid_reg + AW1'(1);
                    end else begin
                        hi_next = mid_reg;
                    end
                end
            end
            default: begin
                mid_next = mid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/sorted_table_binary_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// table of signed 32-bit entries searched by binary search
// ----------------------------------------------------------------------------
// Usage: load the table with write beats (s_tuser = 0) in ascending order,
// set the entry count on the cfg channel, then send search beats
// (s_tuser = 1) carrying the key in the value field. Each search returns
// one beat on the m_ channel: m_tuser is the found flag and m_tdata the
// index of the matching entry (zero when not found). Writes return nothing.
// A search takes two steps per probe, the table memory read and the compare,
// plus a step to detect an empty range when the key is not found. The result
// then sits in the output register; the next beat is taken in the idle state
// that follows, while the result waits.
// If the receiver stalls, a following search holds at its last step until
// the output register frees.
// Reset clears the control state and the entry count; the table contents
// are undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // entry_index[9:0], entry_value[41:10], zero fill
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // match_index[9:0], zero fill
    output logic             m_tuser,   // found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data   // entry_count
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [INDEX_W-1:0] m_index_reg, m_index_next;

    logic               out_free;
    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;
    result_t            res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign entry_count_next = (cfg_valid && cfg_ready) ? cfg_data : entry_count_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_index_next = m_index_reg;
        if (res.load) begin
            m_valid_next = 1'b1;
            m_found_next = res.found;
            m_index_next = res.index;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            entry_count_reg <= entry_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_index_reg <= m_index_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {6'b0, m_index_reg};

    sts_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .operation   (s_tuser),
        .entry_index (s_tdata[9:0]),
        .entry_value (s_tdata[41:10]),
        .entry_count (entry_count_reg),
        .out_free    (out_free),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res         (res)
    );

    sts_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[41:10]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire
